@@ sv/qeacc_pkg.sv @@
// shared types, constants and the quadrature table for the encoder decoder
// no dependencies; used by every module of the block
`default_nettype none

package qeacc_pkg;

  localparam int ENCODER_SLOTS = 16;
  localparam int SLOT_W        = 4;
  localparam int TIME_W        = 32;
  localparam int CFG_DATA_W    = 8;
  localparam int CFG_INDEX_W   = 2;
  localparam int LIMIT_W       = 8;
  localparam int FACTOR_W      = 7;
  localparam int INC_W         = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_FAST_LIMIT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MEDIUM_LIMIT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAST_FACTOR   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MEDIUM_FACTOR = 2'd3;

  localparam logic [LIMIT_W-1:0]  FAST_LIMIT_RST    = 8'd6;
  localparam logic [LIMIT_W-1:0]  MEDIUM_LIMIT_RST  = 8'd10;
  localparam logic [FACTOR_W-1:0] FAST_FACTOR_RST   = 7'd100;
  localparam logic [FACTOR_W-1:0] MEDIUM_FACTOR_RST = 7'd10;

  localparam logic signed [2:0] ACC_MAX  = 3'sd3;
  localparam logic signed [2:0] ACC_MIN  = -3'sd3;
  localparam logic signed [2:0] STEP_POS = 3'sd2;
  localparam logic signed [2:0] STEP_NEG = -3'sd2;

  typedef struct packed {
    logic [LIMIT_W-1:0]  fast_limit_ms;
    logic [LIMIT_W-1:0]  medium_limit_ms;
    logic [FACTOR_W-1:0] fast_factor;
    logic [FACTOR_W-1:0] medium_factor;
  } cfg_t;

  // per-slot record: previous {b, a}, accumulator, time of last step
  typedef struct packed {
    logic [1:0]        prev_ab;
    logic signed [2:0] accum;
    logic [TIME_W-1:0] last_time;
  } slot_state_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    slot_state_t       state;
  } slot_write_t;

  // delta for index {prev_b, prev_a, b, a}
  function automatic logic signed [2:0] quad_delta(input logic [3:0] idx);
    logic signed [2:0] d;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: d = -3'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: d = 3'sd1;
      default:                  d = 3'sd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ sv/qeacc_cfg_regs.sv @@
// configuration registers of the encoder decoder
// depends on qeacc_pkg
`default_nettype none

module qeacc_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [qeacc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [qeacc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output qeacc_pkg::cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_limit_ms   <= qeacc_pkg::FAST_LIMIT_RST;
      cfg.medium_limit_ms <= qeacc_pkg::MEDIUM_LIMIT_RST;
      cfg.fast_factor     <= qeacc_pkg::FAST_FACTOR_RST;
      cfg.medium_factor   <= qeacc_pkg::MEDIUM_FACTOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qeacc_pkg::CFG_FAST_LIMIT:    cfg.fast_limit_ms   <= cfg_data;
        qeacc_pkg::CFG_MEDIUM_LIMIT:  cfg.medium_limit_ms <= cfg_data;
        qeacc_pkg::CFG_FAST_FACTOR:   cfg.fast_factor     <= cfg_data[qeacc_pkg::FACTOR_W-1:0];
        qeacc_pkg::CFG_MEDIUM_FACTOR: cfg.medium_factor   <= cfg_data[qeacc_pkg::FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/qeacc_slot_store.sv @@
// per-slot encoder state held in flip-flops, one read and one write port
// depends on qeacc_pkg
`default_nettype none

module qeacc_slot_store (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [qeacc_pkg::SLOT_W-1:0]  rd_slot,
  output qeacc_pkg::slot_state_t             rd_state,
  input  qeacc_pkg::slot_write_t             wr
);

  qeacc_pkg::slot_state_t slots [qeacc_pkg::ENCODER_SLOTS];

  assign rd_state = slots[rd_slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < qeacc_pkg::ENCODER_SLOTS; i++) begin
        slots[i] <= '0;
      end
    end else if (wr.en) begin
      slots[wr.slot] <= wr.state;
    end
  end

endmodule

`default_nettype wire

@@ sv/qeacc_step_logic.sv @@
// combinational update of one slot: quadrature accumulate, detent step, speed factor
// depends on qeacc_pkg
`default_nettype none

module qeacc_step_logic (
  input  qeacc_pkg::cfg_t                       cfg,
  input  qeacc_pkg::slot_state_t                cur,
  input  wire logic                             a_level,
  input  wire logic                             b_level,
  input  wire logic [qeacc_pkg::TIME_W-1:0]     now_ms,
  output qeacc_pkg::slot_state_t                nxt,
  output logic signed [qeacc_pkg::INC_W-1:0]    increment
);

  logic [1:0]                      curr_ab;
  logic signed [3:0]               acc_sum;
  logic signed [2:0]               acc_sat;
  logic                            detent;
  logic                            dir_pos;
  logic                            dir_neg;
  logic                            step;
  logic [qeacc_pkg::TIME_W-1:0]    gap;
  logic [qeacc_pkg::FACTOR_W-1:0]  factor;
  logic [qeacc_pkg::INC_W-1:0]     factor_ext;

  assign curr_ab = {b_level, a_level};
  assign acc_sum = 4'(cur.accum) + 4'(qeacc_pkg::quad_delta({cur.prev_ab, curr_ab}));

  always_comb begin
    if (acc_sum > 4'(qeacc_pkg::ACC_MAX)) begin
      acc_sat = qeacc_pkg::ACC_MAX;
    end else if (acc_sum < 4'(qeacc_pkg::ACC_MIN)) begin
      acc_sat = qeacc_pkg::ACC_MIN;
    end else begin
      acc_sat = acc_sum[2:0];
    end
  end

  assign detent  = (curr_ab == 2'b00);
  assign dir_pos = detent && (acc_sat >= qeacc_pkg::STEP_POS);
  assign dir_neg = detent && (acc_sat <= qeacc_pkg::STEP_NEG);
  assign step    = dir_pos || dir_neg;

  // wrapping gap since the last step, nested limit tests
  assign gap = now_ms - cur.last_time;

  always_comb begin
    if (gap < qeacc_pkg::TIME_W'(cfg.medium_limit_ms)) begin
      if (gap < qeacc_pkg::TIME_W'(cfg.fast_limit_ms)) begin
        factor = cfg.fast_factor;
      end else begin
        factor = cfg.medium_factor;
      end
    end else begin
      factor = qeacc_pkg::FACTOR_W'(1);
    end
  end

  assign factor_ext = qeacc_pkg::INC_W'(factor);

  always_comb begin
    if (dir_pos) begin
      increment = factor_ext;
    end else if (dir_neg) begin
      increment = -factor_ext;
    end else begin
      increment = '0;
    end
  end

  assign nxt.prev_ab   = curr_ab;
  assign nxt.accum     = detent ? 3'sd0 : acc_sat;
  assign nxt.last_time = step ? now_ms : cur.last_time;

endmodule

`default_nettype wire

@@ sv/quadrature_encoder_accel_decoder.sv @@
// top level of the quadrature encoder decoder with speed-scaled increments
// depends on qeacc_pkg, qeacc_cfg_regs, qeacc_slot_store, qeacc_step_logic
// a poll passes from its input transaction through the input register, then the result register, to result offered
// throughput: one poll per cycle while no held result stalls the input; a poll reads its slot and
//   rewrites it as it leaves the input stage, so polls of the same slot may follow each other with no gap
// reset (rst, synchronous): all slot state zero, registers to defaults, both stages empty
`default_nettype none

module quadrature_encoder_accel_decoder (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // poll channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [qeacc_pkg::SLOT_W-1:0]         encoder_slot,
  input  wire logic                                 a_level,
  input  wire logic                                 b_level,
  input  wire logic [qeacc_pkg::TIME_W-1:0]         now_ms,
  // result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [qeacc_pkg::INC_W-1:0]        increment,
  // configuration write port
  input  wire logic                                 cfg_we,
  input  wire logic [qeacc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [qeacc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // input register stage
  logic                              s1_valid;
  logic [qeacc_pkg::SLOT_W-1:0]      s1_slot;
  logic                              s1_a;
  logic                              s1_b;
  logic [qeacc_pkg::TIME_W-1:0]      s1_now;

  logic                              in_take;
  logic                              advance;
  logic                              slot_ok;

  qeacc_pkg::cfg_t                   cfg;
  qeacc_pkg::slot_state_t            rd_state;
  qeacc_pkg::slot_state_t            nxt_state;
  qeacc_pkg::slot_write_t            wr;
  logic signed [qeacc_pkg::INC_W-1:0] step_inc;

  // the input stage moves on whenever the result register is empty or being drained;
  // a held result stalls the input only while the input stage is also full
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  // polls of slots outside the table change nothing and give zero
  assign slot_ok = (32'(s1_slot) < qeacc_pkg::ENCODER_SLOTS);

  qeacc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qeacc_slot_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_slot  (s1_slot),
    .rd_state (rd_state),
    .wr       (wr)
  );

  qeacc_step_logic u_step (
    .cfg       (cfg),
    .cur       (rd_state),
    .a_level   (s1_a),
    .b_level   (s1_b),
    .now_ms    (s1_now),
    .nxt       (nxt_state),
    .increment (step_inc)
  );

  // slot write lands on the same edge as the result, so the next poll sees it
  assign wr.en    = advance && slot_ok;
  assign wr.slot  = s1_slot;
  assign wr.state = nxt_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // payload of the input stage, loaded on every input transaction
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_slot <= encoder_slot;
      s1_a    <= a_level;
      s1_b    <= b_level;
      s1_now  <= now_ms;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      increment <= slot_ok ? step_inc : '0;
    end
  end

  // the input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // a poll in the input stage reaches the result register once it can move
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !(out_valid && out_stall)) |=> out_valid)
    else $error("poll advanced but no result appeared");

  // the stored accumulator never leaves its saturation range
  a_accum_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (rd_state.accum != 3'sb100))
    else $error("slot accumulator out of range");

endmodule

`default_nettype wire

@@ sim/quadrature_encoder_accel_decoder_tb.sv @@
// self-checking testbench for the quadrature encoder decoder with speed-scaled increments
// depends on qeacc_pkg and quadrature_encoder_accel_decoder; no files or arguments needed
`timescale 1ns / 1ps

module quadrature_encoder_accel_decoder_tb;

  localparam int CYCLE_LIMIT = 100000;  // far beyond the slowest correct run
  localparam int LONG_HOLD   = 200;     // receiver back-pressure stretch, in cycles
  localparam int SETTLE      = 4;       // idle cycles before a register write
  localparam int DRAIN       = 8;       // cycles watched for stray results at the end
  localparam int REPORT_MAX  = 10;
  localparam int N_DIRECTED  = 22;

  // register indexes in write order
  localparam logic [qeacc_pkg::CFG_INDEX_W-1:0] REG_ORDER [4] = '{
    qeacc_pkg::CFG_FAST_LIMIT, qeacc_pkg::CFG_MEDIUM_LIMIT,
    qeacc_pkg::CFG_FAST_FACTOR, qeacc_pkg::CFG_MEDIUM_FACTOR
  };

  // pin states as {b, a}
  localparam logic [1:0] AB_DETENT = 2'b00;
  localparam logic [1:0] AB_A_ONLY = 2'b01;
  localparam logic [1:0] AB_B_ONLY = 2'b10;
  localparam logic [1:0] AB_BOTH   = 2'b11;

  // ---------------------------------------------------------------------------
  // clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                    in_valid     = 1'b0;
  logic                                    in_stall;
  logic [qeacc_pkg::SLOT_W-1:0]            encoder_slot = '0;
  logic                                    a_level      = 1'b0;
  logic                                    b_level      = 1'b0;
  logic [qeacc_pkg::TIME_W-1:0]            now_ms       = '0;
  logic                                    out_valid;
  logic                                    out_stall    = 1'b0;
  logic signed [qeacc_pkg::INC_W-1:0]      increment;
  logic                                    cfg_we       = 1'b0;
  logic [qeacc_pkg::CFG_INDEX_W-1:0]       cfg_index    = '0;
  logic [qeacc_pkg::CFG_DATA_W-1:0]        cfg_data     = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  quadrature_encoder_accel_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .encoder_slot (encoder_slot),
    .a_level      (a_level),
    .b_level      (b_level),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .increment    (increment),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // decoder prediction: own copy of every slot and of the speed settings
  // ---------------------------------------------------------------------------
  // accumulator change indexed by {prev b, prev a, b, a}; a double change counts as zero
  int quad_step [16] = '{
     0, -1,  1,  0,
     1,  0,  0, -1,
    -1,  0,  0,  1,
     0,  1, -1,  0
  };

  logic [1:0]                   slot_prev_ab [qeacc_pkg::ENCODER_SLOTS];
  int                           slot_accum   [qeacc_pkg::ENCODER_SLOTS];
  logic [qeacc_pkg::TIME_W-1:0] slot_last_ms [qeacc_pkg::ENCODER_SLOTS];
  qeacc_pkg::cfg_t              speed_cfg;

  // nested thresholds: at or above the medium limit the factor is always 1
  function automatic int speed_factor(input logic [qeacc_pkg::TIME_W-1:0] gap);
    if (gap < qeacc_pkg::TIME_W'(speed_cfg.medium_limit_ms)) begin
      if (gap < qeacc_pkg::TIME_W'(speed_cfg.fast_limit_ms))
        return int'(speed_cfg.fast_factor);
      return int'(speed_cfg.medium_factor);
    end
    return 1;
  endfunction

  // one poll: update the slot and return the increment it should produce
  function automatic logic signed [qeacc_pkg::INC_W-1:0] advance_encoder(
    input logic [qeacc_pkg::SLOT_W-1:0] slot,
    input logic                         a,
    input logic                         b,
    input logic [qeacc_pkg::TIME_W-1:0] now
  );
    logic [1:0] cur_ab;
    int         acc;
    int         dir;
    int         inc;
    cur_ab = {b, a};
    acc = slot_accum[slot] + quad_step[{slot_prev_ab[slot], cur_ab}];
    slot_prev_ab[slot] = cur_ab;
    if (acc > int'(qeacc_pkg::ACC_MAX)) acc = int'(qeacc_pkg::ACC_MAX);
    if (acc < int'(qeacc_pkg::ACC_MIN)) acc = int'(qeacc_pkg::ACC_MIN);
    dir = 0;
    // detent: decide the direction, then start afresh
    if (cur_ab == AB_DETENT) begin
      if (acc >= int'(qeacc_pkg::STEP_POS)) dir = 1;
      else if (acc <= int'(qeacc_pkg::STEP_NEG)) dir = -1;
      acc = 0;
    end
    slot_accum[slot] = acc;
    inc = 0;
    // a step with a zero factor still records its time
    if (dir != 0) begin
      inc = dir * speed_factor(now - slot_last_ms[slot]);
      slot_last_ms[slot] = now;
    end
    return inc[qeacc_pkg::INC_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // shared bookkeeping
  // ---------------------------------------------------------------------------
  logic signed [qeacc_pkg::INC_W-1:0] expected_increments [$];
  int  fault_count   = 0;
  int  cycle_count   = 0;
  int  polls_sent    = 0;
  bit  no_gaps       = 1'b0;  // both sides run flat out while set
  bit  long_hold_req = 1'b0;  // asks the receiver for one long stall
  logic [qeacc_pkg::TIME_W-1:0] ms_clock = '0;

  // ---------------------------------------------------------------------------
  // directed polls; expectations typed in where they are obvious
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [qeacc_pkg::SLOT_W-1:0]       slot;
    logic                               a;
    logic                               b;
    logic [qeacc_pkg::TIME_W-1:0]       now;
    bit                                 typed;
    logic signed [qeacc_pkg::INC_W-1:0] want;
  } poll_row_t;

  poll_row_t directed_polls [N_DIRECTED] = '{
    // slot 0, full forward turn from reset, saturating the accumulator: long gap
    '{4'd0,  1'b0, 1'b1, 32'd1000,       1'b1,  8'sd0},
    '{4'd0,  1'b1, 1'b1, 32'd1000,       1'b1,  8'sd0},
    '{4'd0,  1'b1, 1'b0, 32'd1000,       1'b1,  8'sd0},
    '{4'd0,  1'b0, 1'b0, 32'd1000,       1'b1,  8'sd1},
    // forward half turn then a jump of both pins back to detent, 3 ms later
    '{4'd0,  1'b0, 1'b1, 32'd1003,       1'b1,  8'sd0},
    '{4'd0,  1'b1, 1'b1, 32'd1003,       1'b1,  8'sd0},
    '{4'd0,  1'b0, 1'b0, 32'd1003,       1'b1,  8'sd100},
    // backward, 7 ms later: medium band
    '{4'd0,  1'b1, 1'b0, 32'd1010,       1'b1,  8'sd0},
    '{4'd0,  1'b1, 1'b1, 32'd1010,       1'b1,  8'sd0},
    '{4'd0,  1'b0, 1'b0, 32'd1010,       1'b0,  8'sd0},
    // backward, exactly on the medium limit
    '{4'd0,  1'b1, 1'b0, 32'd1020,       1'b1,  8'sd0},
    '{4'd0,  1'b1, 1'b1, 32'd1020,       1'b1,  8'sd0},
    '{4'd0,  1'b0, 1'b0, 32'd1020,       1'b0,  8'sd0},
    // one edge out and back: no step
    '{4'd0,  1'b0, 1'b1, 32'd1021,       1'b1,  8'sd0},
    '{4'd0,  1'b0, 1'b0, 32'd1021,       1'b1,  8'sd0},
    // top slot at the end of time, then a step across the wrap
    '{4'd15, 1'b0, 1'b1, 32'hFFFF_FFFF,  1'b1,  8'sd0},
    '{4'd15, 1'b1, 1'b1, 32'hFFFF_FFFF,  1'b1,  8'sd0},
    '{4'd15, 1'b0, 1'b0, 32'hFFFF_FFFF,  1'b1,  8'sd1},
    '{4'd15, 1'b1, 1'b0, 32'h0000_0000,  1'b1,  8'sd0},
    '{4'd15, 1'b1, 1'b1, 32'h0000_0000,  1'b1,  8'sd0},
    '{4'd15, 1'b0, 1'b0, 32'h0000_0004,  1'b1, -8'sd100},
    // both pins rise at once from rest
    '{4'd7,  1'b1, 1'b1, 32'h8000_0000,  1'b1,  8'sd0}
  };

  // ---------------------------------------------------------------------------
  // poll sender
  // ---------------------------------------------------------------------------
  // offers one poll after a random gap and records its expectation on acceptance
  task automatic send_poll(
    input logic [qeacc_pkg::SLOT_W-1:0]       slot,
    input logic                               a,
    input logic                               b,
    input logic [qeacc_pkg::TIME_W-1:0]       now,
    input bit                                 typed,
    input logic signed [qeacc_pkg::INC_W-1:0] want
  );
    int                                 gap;
    logic signed [qeacc_pkg::INC_W-1:0] predicted;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    encoder_slot <= slot;
    a_level      <= a;
    b_level      <= b;
    now_ms       <= now;
    do @(posedge clk); while (in_stall);
    predicted = advance_encoder(slot, a, b, now);
    expected_increments.push_back(typed ? want : predicted);
    polls_sent++;
  endtask

  // free-running time: mostly small steps, now and then a jump anywhere
  function automatic logic [qeacc_pkg::TIME_W-1:0] next_ms();
    ms_clock += $urandom_range(0, 3);
    if ($urandom_range(0, 39) == 0) ms_clock = $urandom;
    return ms_clock;
  endfunction

  // one well-formed movement towards a detent, in one of several shapes
  task automatic turn_detent(input logic [qeacc_pkg::SLOT_W-1:0] slot);
    logic [1:0] path [$];
    logic [1:0] lead;
    logic [1:0] trail;
    int         shape;
    lead  = $urandom_range(0, 1) ? AB_B_ONLY : AB_A_ONLY;
    trail = (lead == AB_B_ONLY) ? AB_A_ONLY : AB_B_ONLY;
    shape = $urandom_range(0, 3);
    path.push_back(lead);
    case (shape)
      0: begin  // clean full turn
        path.push_back(AB_BOTH);
        path.push_back(trail);
      end
      1: begin  // skipped state, both pins drop together
        path.push_back(AB_BOTH);
      end
      2: begin  // contact bounce partway round
        path.push_back(AB_BOTH);
        path.push_back(lead);
        path.push_back(AB_BOTH);
        path.push_back(trail);
      end
      default: ;  // aborted turn, straight back to rest
    endcase
    path.push_back(AB_DETENT);
    foreach (path[i]) send_poll(slot, path[i][0], path[i][1], next_ms(), 1'b0, '0);
  endtask

  // random polls: mostly turns on a favoured slot, the rest anything at all
  task automatic run_phase(input int polls);
    int                           phase_end;
    logic [qeacc_pkg::SLOT_W-1:0] hot_slot;
    logic [qeacc_pkg::SLOT_W-1:0] slot;
    hot_slot  = qeacc_pkg::SLOT_W'($urandom_range(0, qeacc_pkg::ENCODER_SLOTS - 1));
    phase_end = polls_sent + polls;
    while (polls_sent < phase_end) begin
      no_gaps = (polls_sent % 80) < 20;
      slot = ($urandom_range(0, 9) < 6) ? hot_slot :
             qeacc_pkg::SLOT_W'($urandom_range(0, qeacc_pkg::ENCODER_SLOTS - 1));
      if ($urandom_range(0, 9) < 7) begin
        turn_detent(slot);
      end else begin
        send_poll(slot, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  ($urandom_range(0, 3) == 0) ? $urandom : next_ms(), 1'b0, '0);
      end
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // register writes, only once the block has drained
  // ---------------------------------------------------------------------------
  task automatic load_settings(
    input logic [qeacc_pkg::CFG_DATA_W-1:0] fast_lim,
    input logic [qeacc_pkg::CFG_DATA_W-1:0] med_lim,
    input logic [qeacc_pkg::CFG_DATA_W-1:0] fast_fac,
    input logic [qeacc_pkg::CFG_DATA_W-1:0] med_fac
  );
    logic [qeacc_pkg::CFG_DATA_W-1:0] vals [4];
    vals = '{fast_lim, med_lim, fast_fac, med_fac};
    in_valid <= 1'b0;
    while (expected_increments.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      // factors keep only their low bits, so a value with only bit 7 set gives a zero factor
      case (REG_ORDER[i])
        qeacc_pkg::CFG_FAST_LIMIT:    speed_cfg.fast_limit_ms   = vals[i];
        qeacc_pkg::CFG_MEDIUM_LIMIT:  speed_cfg.medium_limit_ms = vals[i];
        qeacc_pkg::CFG_FAST_FACTOR:
          speed_cfg.fast_factor   = vals[i][qeacc_pkg::FACTOR_W-1:0];
        qeacc_pkg::CFG_MEDIUM_FACTOR:
          speed_cfg.medium_factor = vals[i][qeacc_pkg::FACTOR_W-1:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result receiver: random stalls, plus one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = no_gaps ? 0 : $urandom_range(0, 7);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every accepted transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    logic signed [qeacc_pkg::INC_W-1:0] want_inc;
    if (!rst && out_valid && !out_stall) begin
      if (expected_increments.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("unexpected result transaction: increment %0d", increment);
      end else begin
        want_inc = expected_increments.pop_front();
        if (increment !== want_inc) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("increment mismatch: expected %0d, got %0d", want_inc, increment);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    for (int s = 0; s < qeacc_pkg::ENCODER_SLOTS; s++) begin
      slot_prev_ab[s] = AB_DETENT;
      slot_accum[s]   = 0;
      slot_last_ms[s] = '0;
    end
    speed_cfg = '{qeacc_pkg::FAST_LIMIT_RST, qeacc_pkg::MEDIUM_LIMIT_RST,
                  qeacc_pkg::FAST_FACTOR_RST, qeacc_pkg::MEDIUM_FACTOR_RST};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed polls under the reset settings
    for (int r = 0; r < N_DIRECTED; r++)
      send_poll(directed_polls[r].slot, directed_polls[r].a, directed_polls[r].b,
                directed_polls[r].now, directed_polls[r].typed, directed_polls[r].want);
    run_phase(60);

    // zero limits: every step is plain +/-1
    load_settings(8'h00, 8'h00, 8'h01, 8'h01);
    run_phase(85);

    // widest limits and largest factors, with the output held back for a while
    load_settings(8'hFF, 8'hFF, 8'h7F, 8'h7F);
    long_hold_req = 1'b1;
    run_phase(85);

    // fast limit above medium limit, fast factor zero
    load_settings(8'd200, 8'd5, 8'h80, 8'd3);
    run_phase(85);

    // medium factor zero
    load_settings(8'd4, 8'd12, 8'h7F, 8'h80);
    run_phase(85);

    // anything goes
    load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_phase(85);

    // back to the reset values, with a second long hold
    load_settings(qeacc_pkg::FAST_LIMIT_RST, qeacc_pkg::MEDIUM_LIMIT_RST,
                  {1'b0, qeacc_pkg::FAST_FACTOR_RST}, {1'b0, qeacc_pkg::MEDIUM_FACTOR_RST});
    long_hold_req = 1'b1;
    run_phase(85);

    // drain, then watch a little longer for stray results
    in_valid <= 1'b0;
    while (expected_increments.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (fault_count == 0 && expected_increments.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
